[src/ddp_pkg.sv]
package ddp_pkg;

    // packet sizing
    localparam int MAX_PAYLOAD = 1440;
    localparam int LEN_W       = 11;
    localparam int OFFSET_W    = 24;
    localparam int SEQ_W       = 4;
    localparam int HDR_LEN     = 10;
    localparam int HDR_IDX_W   = 4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // header flag bits
    localparam logic [7:0] FLAG_VER1 = 8'h40;
    localparam logic [7:0] FLAG_PUSH = 8'h01;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_AUTO_PUSH      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_TYPE_CODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DESTINATION_ID = 2'd2;

    // configuration reset values
    localparam logic       AUTO_PUSH_RST      = 1'b1;
    localparam logic [7:0] DATA_TYPE_CODE_RST = 8'd11;
    localparam logic [7:0] DESTINATION_ID_RST = 8'd1;

    // header byte positions
    localparam logic [HDR_IDX_W-1:0] HB_FLAGS     = 4'd0;
    localparam logic [HDR_IDX_W-1:0] HB_SEQ       = 4'd1;
    localparam logic [HDR_IDX_W-1:0] HB_DATA_TYPE = 4'd2;
    localparam logic [HDR_IDX_W-1:0] HB_DEST_ID   = 4'd3;
    localparam logic [HDR_IDX_W-1:0] HB_OFF_3     = 4'd4;
    localparam logic [HDR_IDX_W-1:0] HB_OFF_2     = 4'd5;
    localparam logic [HDR_IDX_W-1:0] HB_OFF_1     = 4'd6;
    localparam logic [HDR_IDX_W-1:0] HB_OFF_0     = 4'd7;
    localparam logic [HDR_IDX_W-1:0] HB_LEN_HI    = 4'd8;
    localparam logic [HDR_IDX_W-1:0] HB_LEN_LO    = 4'd9;
    localparam logic [HDR_IDX_W-1:0] HB_DONE      = 4'd10;

    typedef struct packed {
        logic [7:0]          data_byte;
        logic [OFFSET_W-1:0] frame_length;
    } pix_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_header;
        logic       packet_last;
    } pkt_t;

    typedef struct packed {
        logic       auto_push;
        logic [7:0] data_type_code;
        logic [7:0] destination_id;
    } cfg_t;

    // one classified request: payload byte plus header fields when it opens a packet
    typedef struct packed {
        logic [7:0]          data_byte;
        logic                packet_last;
        logic                opens;
        logic                push;
        logic [SEQ_W-1:0]    seq;
        logic [OFFSET_W-1:0] offset;
        logic [LEN_W-1:0]    len;
    } job_t;

endpackage

[src/ddp_front.sv]
module ddp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  ddp_pkg::pix_t pix,
    input  ddp_pkg::cfg_t cfg,
    output ddp_pkg::job_t job
);

    logic [ddp_pkg::OFFSET_W-1:0] offset_reg, offset_next;
    logic [ddp_pkg::SEQ_W-1:0]    seq_reg, seq_next;
    logic [ddp_pkg::LEN_W-1:0]    left_reg, left_next;

    logic [ddp_pkg::OFFSET_W-1:0] flen;
    logic                         opens;
    logic [ddp_pkg::OFFSET_W-1:0] offset_base;
    logic [ddp_pkg::OFFSET_W-1:0] remaining;
    logic                         final_packet;
    logic [ddp_pkg::LEN_W-1:0]    len;
    logic [ddp_pkg::LEN_W-1:0]    left_cur;
    logic                         last;
    logic [ddp_pkg::OFFSET_W-1:0] offset_inc;

    // packet start classification
    always_comb
    begin
        flen         = (pix.frame_length == '0) ? ddp_pkg::OFFSET_W'(1) : pix.frame_length;
        opens        = (left_reg == '0);
        offset_base  = (opens && (offset_reg >= flen)) ? '0 : offset_reg;
        remaining    = flen - offset_base;
        final_packet = (remaining <= ddp_pkg::OFFSET_W'(ddp_pkg::MAX_PAYLOAD));
        len          = final_packet ? remaining[ddp_pkg::LEN_W-1:0]
                                    : ddp_pkg::LEN_W'(ddp_pkg::MAX_PAYLOAD);
        left_cur     = opens ? len : left_reg;
        left_next    = left_cur - ddp_pkg::LEN_W'(1);
        last         = (left_next == '0);
        offset_inc   = offset_base + ddp_pkg::OFFSET_W'(1);
        offset_next  = (last && (offset_inc >= flen)) ? '0 : offset_inc;
        seq_next     = opens ? seq_reg + ddp_pkg::SEQ_W'(1) : seq_reg;
    end

    // request toward the queue
    always_comb
    begin
        job.data_byte   = pix.data_byte;
        job.packet_last = last;
        job.opens       = opens;
        job.push        = cfg.auto_push & final_packet;
        job.seq         = seq_reg;
        job.offset      = offset_base;
        job.len         = len;
    end

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            seq_reg    <= '0;
            left_reg   <= '0;
        end
        else if (accept)
        begin
            offset_reg <= offset_next;
            seq_reg    <= seq_next;
            left_reg   <= left_next;
        end
    end

endmodule

[src/ddp_queue.sv]
module ddp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ddp_pkg::job_t wr_job,
    output logic          full,
    input  logic          pop,
    output logic          rd_valid,
    output ddp_pkg::job_t rd_job
);

    ddp_pkg::job_t              entry_reg [ddp_pkg::QUEUE_DEPTH];
    logic [ddp_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ddp_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ddp_pkg::QCNT_W-1:0] count_reg, count_next;

    // status and head entry
    assign full     = (count_reg == ddp_pkg::QCNT_W'(ddp_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_job   = entry_reg[rd_ptr_reg];

    // pointer wrap
    always_comb
    begin
        wr_ptr_next = (wr_ptr_reg == ddp_pkg::QPTR_W'(ddp_pkg::QUEUE_DEPTH - 1))
                      ? '0 : wr_ptr_reg + ddp_pkg::QPTR_W'(1);
        rd_ptr_next = (rd_ptr_reg == ddp_pkg::QPTR_W'(ddp_pkg::QUEUE_DEPTH - 1))
                      ? '0 : rd_ptr_reg + ddp_pkg::QPTR_W'(1);
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + ddp_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - ddp_pkg::QCNT_W'(1);
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_next;
            if (pop)
                rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_job;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ddp_pkg::QCNT_W'(ddp_pkg::QUEUE_DEPTH))
        else $error("queue count over depth");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push || pop)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd_valid)
        else $error("pop from empty queue");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> count_reg == $past(count_reg) + ddp_pkg::QCNT_W'(1))
        else $error("queue count did not follow push");

endmodule

[src/ddp_back.sv]
module ddp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  ddp_pkg::cfg_t cfg,
    input  logic          q_valid,
    input  ddp_pkg::job_t q_job,
    output logic          q_pop,
    output logic          pkt_valid,
    input  logic          pkt_stall,
    output ddp_pkg::pkt_t pkt
);

    logic [ddp_pkg::HDR_IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic                          valid_reg, valid_next;
    ddp_pkg::pkt_t                 pkt_reg, pkt_next;
    logic                          load;
    logic                          in_header;
    logic [7:0]                    hdr_byte;

    assign load      = !valid_reg || !pkt_stall;
    assign in_header = q_job.opens && (hdr_idx_reg != ddp_pkg::HB_DONE);

    // header byte select
    always_comb
    begin
        case (hdr_idx_reg)
            ddp_pkg::HB_FLAGS:
                hdr_byte = ddp_pkg::FLAG_VER1 | (q_job.push ? ddp_pkg::FLAG_PUSH : 8'h00);
            ddp_pkg::HB_SEQ:       hdr_byte = {{(8 - ddp_pkg::SEQ_W){1'b0}}, q_job.seq};
            ddp_pkg::HB_DATA_TYPE: hdr_byte = cfg.data_type_code;
            ddp_pkg::HB_DEST_ID:   hdr_byte = cfg.destination_id;
            ddp_pkg::HB_OFF_3:     hdr_byte = 8'h00;
            ddp_pkg::HB_OFF_2:     hdr_byte = q_job.offset[23:16];
            ddp_pkg::HB_OFF_1:     hdr_byte = q_job.offset[15:8];
            ddp_pkg::HB_OFF_0:     hdr_byte = q_job.offset[7:0];
            ddp_pkg::HB_LEN_HI:
                hdr_byte = {{(16 - ddp_pkg::LEN_W){1'b0}}, q_job.len[ddp_pkg::LEN_W-1:8]};
            ddp_pkg::HB_LEN_LO:    hdr_byte = q_job.len[7:0];
            default:               hdr_byte = 8'h00;
        endcase
    end

    // header sequencer and output register load
    always_comb
    begin
        hdr_idx_next = hdr_idx_reg;
        valid_next   = valid_reg;
        pkt_next     = pkt_reg;
        q_pop        = 1'b0;
        if (load)
        begin
            valid_next = q_valid;
            if (q_valid)
            begin
                if (in_header)
                begin
                    pkt_next.out_byte    = hdr_byte;
                    pkt_next.is_header   = 1'b1;
                    pkt_next.packet_last = 1'b0;
                    hdr_idx_next         = hdr_idx_reg + ddp_pkg::HDR_IDX_W'(1);
                end
                else
                begin
                    pkt_next.out_byte    = q_job.data_byte;
                    pkt_next.is_header   = 1'b0;
                    pkt_next.packet_last = q_job.packet_last;
                    hdr_idx_next         = '0;
                    q_pop                = 1'b1;
                end
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_idx_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            hdr_idx_reg <= hdr_idx_next;
            valid_reg   <= valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        pkt_reg <= pkt_next;
    end

    assign pkt_valid = valid_reg;
    assign pkt       = pkt_reg;

    // checks
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_idx_reg <= ddp_pkg::HB_DONE)
        else $error("header index out of range");

    a_hdr_then_payload: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !in_header)
        else $error("request popped before its header was sent");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt))
        else $error("output request changed while stalled");

endmodule

[src/ddp_packetizer.sv]
// ddp_packetizer: cuts a stream of frame bytes into display protocol packets.
// pixel channel (pix_valid / pix_stall / pix): one frame byte per request,
// with the frame's total length repeated on every byte of the frame.
// packet channel (pkt_valid / pkt_stall / pkt): one packet byte per request;
// each packet is a 10-byte header (is_header set) followed by up to
// MAX_PAYLOAD payload bytes, packet_last set on the last payload byte.
// config port (cfg_we / cfg_index / cfg_data): index 0 auto_push, 1 data type
// code, 2 destination id; write only while the block is idle.
// with the queue empty, a byte that continues a packet passes through its queue entry
// and the output byte register; a byte that opens a packet follows its header.
// throughput: one payload byte per cycle while pkt_stall is low, plus each packet's
// 10 header bytes, set by the single output byte register of the back end sequencer.
// a 4-entry queue separates classification from output, so input keeps
// flowing while a header goes out until the queue fills.
// reset clears frame offset, sequence number and open packet and loads the
// config defaults (auto_push 1, type 11, destination 1).
// when pkt_stall is high the output byte holds; the queue fills, then
// pix_stall rises; nothing is dropped.
module ddp_packetizer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           pix_valid,
    output logic                           pix_stall,
    input  ddp_pkg::pix_t                  pix,
    output logic                           pkt_valid,
    input  logic                           pkt_stall,
    output ddp_pkg::pkt_t                  pkt,
    input  logic                           cfg_we,
    input  logic [ddp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);

    ddp_pkg::cfg_t cfg_reg;
    ddp_pkg::job_t front_job;
    ddp_pkg::job_t head_job;
    logic          accept;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.auto_push      <= ddp_pkg::AUTO_PUSH_RST;
            cfg_reg.data_type_code <= ddp_pkg::DATA_TYPE_CODE_RST;
            cfg_reg.destination_id <= ddp_pkg::DESTINATION_ID_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ddp_pkg::REG_AUTO_PUSH:      cfg_reg.auto_push      <= cfg_data[0];
                ddp_pkg::REG_DATA_TYPE_CODE: cfg_reg.data_type_code <= cfg_data;
                ddp_pkg::REG_DESTINATION_ID: cfg_reg.destination_id <= cfg_data;
                default:                     cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // input handshake
    assign pix_stall = q_full;
    assign accept    = pix_valid && !pix_stall;

    ddp_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pix    (pix),
        .cfg    (cfg_reg),
        .job    (front_job)
    );

    ddp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (accept),
        .wr_job   (front_job),
        .full     (q_full),
        .pop      (q_pop),
        .rd_valid (q_valid),
        .rd_job   (head_job)
    );

    ddp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_job     (head_job),
        .q_pop     (q_pop),
        .pkt_valid (pkt_valid),
        .pkt_stall (pkt_stall),
        .pkt       (pkt)
    );

endmodule

[test/ddp_packetizer_test.sv]
`timescale 1ns / 1ps

module ddp_packetizer_test;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          pix_valid = 1'b0;
    logic                          pix_stall;
    ddp_pkg::pix_t                 pix       = '0;
    logic                          pkt_valid;
    logic                          pkt_stall = 1'b0;
    ddp_pkg::pkt_t                 pkt;
    logic                          cfg_we    = 1'b0;
    logic [ddp_pkg::CFG_IDX_W-1:0] cfg_index = ddp_pkg::REG_AUTO_PUSH;
    logic [7:0]                    cfg_data  = '0;

    // shadow of the header registers
    logic                          cfg_auto_push = ddp_pkg::AUTO_PUSH_RST;
    logic [7:0]                    cfg_type      = ddp_pkg::DATA_TYPE_CODE_RST;
    logic [7:0]                    cfg_dest      = ddp_pkg::DESTINATION_ID_RST;

    // shadow of the packetizer state
    logic [ddp_pkg::OFFSET_W-1:0]  frame_pos    = '0;
    logic [ddp_pkg::SEQ_W-1:0]     next_seq     = '0;
    logic [ddp_pkg::LEN_W-1:0]     payload_left = '0;

    // packet bytes still owed by the block, oldest first
    ddp_pkg::pkt_t                 pending_bytes [$];

    int                            fail_count = 0;
    int                            gap_pct    = 0;
    int                            stall_pct  = 0;

    ddp_packetizer dut (.*);

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // run limit
    initial
    begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    // packetize one accepted frame byte into the bytes it should produce
    task automatic packetize_byte(input logic [7:0] data,
                                  input logic [ddp_pkg::OFFSET_W-1:0] length_in);
        logic [ddp_pkg::OFFSET_W-1:0] length;
        logic [ddp_pkg::OFFSET_W-1:0] remaining;
        logic [ddp_pkg::LEN_W-1:0]    len;
        logic [7:0]                   hdr [ddp_pkg::HDR_LEN];
        logic                         last;
        ddp_pkg::pkt_t                owed;
        length = (length_in == '0) ? ddp_pkg::OFFSET_W'(1) : length_in;
        if (payload_left == '0)
        begin
            // a new packet opens: restart the frame if the offset ran past its end
            if (frame_pos >= length)
                frame_pos = '0;
            remaining = length - frame_pos;
            len = (remaining < ddp_pkg::OFFSET_W'(ddp_pkg::MAX_PAYLOAD))
                  ? remaining[ddp_pkg::LEN_W-1:0] : ddp_pkg::LEN_W'(ddp_pkg::MAX_PAYLOAD);
            hdr[ddp_pkg::HB_FLAGS] = ddp_pkg::FLAG_VER1;
            if (cfg_auto_push && (frame_pos + ddp_pkg::OFFSET_W'(len) >= length))
                hdr[ddp_pkg::HB_FLAGS] = ddp_pkg::FLAG_VER1 | ddp_pkg::FLAG_PUSH;
            hdr[ddp_pkg::HB_SEQ]       = 8'(next_seq);
            hdr[ddp_pkg::HB_DATA_TYPE] = cfg_type;
            hdr[ddp_pkg::HB_DEST_ID]   = cfg_dest;
            hdr[ddp_pkg::HB_OFF_3]     = 8'h00;
            hdr[ddp_pkg::HB_OFF_2]     = frame_pos[23:16];
            hdr[ddp_pkg::HB_OFF_1]     = frame_pos[15:8];
            hdr[ddp_pkg::HB_OFF_0]     = frame_pos[7:0];
            hdr[ddp_pkg::HB_LEN_HI]    = 8'(len >> 8);
            hdr[ddp_pkg::HB_LEN_LO]    = len[7:0];
            foreach (hdr[i])
            begin
                owed.out_byte    = hdr[i];
                owed.is_header   = 1'b1;
                owed.packet_last = 1'b0;
                pending_bytes.insert(pending_bytes.size(), owed);
            end
            next_seq     = next_seq + 1'b1;
            payload_left = len;
        end
        // the payload byte itself
        payload_left = payload_left - 1'b1;
        last = (payload_left == '0);
        owed.out_byte    = data;
        owed.is_header   = 1'b0;
        owed.packet_last = last;
        pending_bytes.insert(pending_bytes.size(), owed);
        frame_pos = frame_pos + 1'b1;
        if (last && frame_pos >= length)
            frame_pos = '0;
    endtask

    // present one frame byte, with a random gap first, and wait for the request to go
    task automatic send_pixel(input logic [7:0] data,
                              input logic [ddp_pkg::OFFSET_W-1:0] length);
        if ($urandom_range(99) < gap_pct)
        begin
            pix_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        pix_valid <= 1'b1;
        pix       <= '{data_byte: data, frame_length: length};
        do @(posedge clk); while (pix_stall);
        packetize_byte(data, length);
    endtask

    // a complete frame of random bytes
    task automatic send_frame(input logic [ddp_pkg::OFFSET_W-1:0] length);
        for (int i = 0; i < int'(length); i++)
            send_pixel(8'($urandom), length);
    endtask

    // hold the sender off until every owed byte has come out
    task automatic wait_for_results();
        pix_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    // write all three header registers, block idle
    task automatic load_header_config(input logic ap, input logic [7:0] dtc,
                                      input logic [7:0] did);
        cfg_we    <= 1'b1;
        cfg_index <= ddp_pkg::REG_AUTO_PUSH;
        cfg_data  <= {7'b0, ap};
        @(posedge clk);
        cfg_auto_push = ap;
        cfg_index <= ddp_pkg::REG_DATA_TYPE_CODE;
        cfg_data  <= dtc;
        @(posedge clk);
        cfg_type = dtc;
        cfg_index <= ddp_pkg::REG_DESTINATION_ID;
        cfg_data  <= did;
        @(posedge clk);
        cfg_dest = did;
        cfg_we <= 1'b0;
    endtask

    // field extremes and the length corner cases at reset settings
    task automatic test_directed();
        // one-byte frame, then a zero length taken as one
        send_pixel(8'h00, 24'd1);
        send_pixel(8'hFF, 24'd0);
        send_pixel(8'h55, 24'd3);
        send_pixel(8'hAA, 24'd3);
        send_pixel(8'h0F, 24'd3);
        // length changes inside the packet, packet keeps its length
        send_pixel(8'h01, 24'd4);
        send_pixel(8'h80, 24'd4);
        send_pixel(8'hF0, 24'hFFFFFF);
        send_pixel(8'h7E, 24'd4);
        // packet ends short of a grown length, next packet finds offset past end
        send_pixel(8'h11, 24'd3);
        send_pixel(8'h22, 24'd3);
        send_pixel(8'h33, 24'd10);
        send_pixel(8'h44, 24'd2);
        send_pixel(8'h99, 24'd2);
    endtask

    // header register extremes
    task automatic test_header_config();
        wait_for_results();
        load_header_config(1'b0, 8'h00, 8'h00);
        send_frame(24'd2);
        wait_for_results();
        load_header_config(1'b1, 8'hFF, 8'hFF);
        send_frame(24'd1);
        send_frame(24'd3);
        wait_for_results();
        load_header_config(1'b0, 8'hA5, 8'h5A);
        send_frame(24'd2);
        wait_for_results();
        load_header_config(ddp_pkg::AUTO_PUSH_RST, ddp_pkg::DATA_TYPE_CODE_RST,
                           ddp_pkg::DESTINATION_ID_RST);
    endtask

    // a full-size packet opened by the largest frame length
    task automatic test_long_packet();
        gap_pct   = 6;
        stall_pct = 6;
        // close any packet still open so the next byte starts one
        while (payload_left != '0)
            send_pixel(8'($urandom), 24'd1);
        for (int i = 0; i < 6; i++)
            send_pixel(8'($urandom), 24'hFFFFFF);
    endtask

    // random frames: mostly whole frames, some with changing lengths or cut short
    task automatic run_random_frames(input int n_items);
        int                           sent;
        int                           kind;
        int                           flen;
        int                           cut;
        logic [ddp_pkg::OFFSET_W-1:0] odd_len;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(99);
            flen = ($urandom_range(9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
            if (kind < 70)
            begin
                send_frame(ddp_pkg::OFFSET_W'(flen));
                sent += flen;
            end
            else if (kind < 88)
            begin
                // tail of the packet carries unrelated lengths
                flen = $urandom_range(2, 8);
                cut  = $urandom_range(1, flen - 1);
                for (int i = 0; i < flen; i++)
                begin
                    case ($urandom_range(3))
                        0:       odd_len = '0;
                        1:       odd_len = '1;
                        default: odd_len = ddp_pkg::OFFSET_W'($urandom);
                    endcase
                    send_pixel(8'($urandom),
                               (i < cut) ? ddp_pkg::OFFSET_W'(flen) : odd_len);
                end
                sent += flen;
            end
            else
            begin
                // frame cut short, the next frame finishes its packet
                cut = $urandom_range(1, flen);
                for (int i = 0; i < cut; i++)
                    send_pixel(8'($urandom), ddp_pkg::OFFSET_W'(flen));
                sent += cut;
            end
            if ($urandom_range(19) == 0)
                wait_for_results();
        end
    endtask

    // one idling phase with its own header settings
    task automatic test_random_phase(input int gap, input int stall);
        wait_for_results();
        load_header_config(1'($urandom_range(1)), 8'($urandom), 8'($urandom));
        gap_pct   = gap;
        stall_pct = stall;
        run_random_frames(68);
    endtask

    // receiver: random stall and compare against the oldest owed byte
    always @(posedge clk)
    begin : check_packet_bytes
        ddp_pkg::pkt_t want;
        if (rst_n)
        begin
            if (pkt_valid && !pkt_stall)
            begin
                if (pending_bytes.size() == 0)
                begin
                    $error("packet byte %02h arrived with none expected", pkt.out_byte);
                    fail_count++;
                end
                else
                begin
                    want = pending_bytes.pop_front();
                    if (pkt.out_byte !== want.out_byte)
                    begin
                        $error("out_byte expected %02h actual %02h", want.out_byte, pkt.out_byte);
                        fail_count++;
                    end
                    if (pkt.is_header !== want.is_header)
                    begin
                        $error("is_header expected %0b actual %0b", want.is_header, pkt.is_header);
                        fail_count++;
                    end
                    if (pkt.packet_last !== want.packet_last)
                    begin
                        $error("packet_last expected %0b actual %0b",
                               want.packet_last, pkt.packet_last);
                        fail_count++;
                    end
                end
            end
            pkt_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // test sequence
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_header_config();
        test_random_phase(0, 0);
        test_random_phase(53, 0);
        test_random_phase(0, 53);
        test_random_phase(6, 6);
        test_long_packet();
        wait_for_results();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
